// ===== hw/rtl/fccw_pkg.sv =====
// Shared types, codes and helpers for the FAT cluster chain walker.
// No dependencies; imported by every module of the block.
package fccw_pkg;

    localparam int unsigned CLUSTER_W = 28;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned COPY_W    = 4;

    localparam logic [CLUSTER_W-1:0] END_FAT12 = 28'hFF8;
    localparam logic [CLUSTER_W-1:0] END_FAT16 = 28'hFFF8;
    localparam logic [CLUSTER_W-1:0] END_FAT32 = 28'hFFFFFF8;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FATREQ = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FAT12       = 2'd0,
        FAT16       = 2'd1,
        FAT32       = 2'd2,
        FAT_UNKNOWN = 2'd3
    } t_fat_type;

    typedef enum logic [2:0] {
        CFG_FAT_TYPE      = 3'd0,
        CFG_FAT_BASE      = 3'd1,
        CFG_COPY_STRIDE   = 3'd2,
        CFG_NUM_FATS      = 3'd3,
        CFG_DATA_BASE     = 3'd4,
        CFG_CLUSTER_BYTES = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_fat_type          fat_type;
        logic [ADDR_W-1:0]  fat_base;
        logic [ADDR_W-1:0]  copy_stride;
        logic [COPY_W-1:0]  num_fats;
        logic [ADDR_W-1:0]  data_base;
        logic [LEN_W-1:0]   cluster_bytes;
    } t_cfg;

    // Results one item produces, before address calculation.
    typedef struct packed {
        logic [1:0]           cnt;
        t_kind                kind0;
        t_kind                kind1;
        logic [CLUSTER_W-1:0] cluster;
        logic [LEN_W-1:0]     len;
        logic [ADDR_W-1:0]    copy_base;
        t_fat_type            fat_type;
    } t_work;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_res;

    // Cluster size of zero counts as one byte.
    function automatic logic [LEN_W-1:0] eff_csize(input logic [LEN_W-1:0] cb);
        eff_csize = (cb == '0) ? LEN_W'(1) : cb;
    endfunction

endpackage

// ===== hw/rtl/fccw_regs.sv =====
// Configuration register file of the FAT cluster chain walker.
// Depends on fccw_pkg.
module fccw_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output fccw_pkg::t_cfg        o_cfg
);
    import fccw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_type      <= FAT12;
            r_cfg.fat_base      <= 32'd512;
            r_cfg.copy_stride   <= 32'd4608;
            r_cfg.num_fats      <= 4'd2;
            r_cfg.data_base     <= 32'd16896;
            r_cfg.cluster_bytes <= 16'd512;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FAT_TYPE:      r_cfg.fat_type      <= t_fat_type'(i_cfg_data[1:0]);
                CFG_FAT_BASE:      r_cfg.fat_base      <= i_cfg_data;
                CFG_COPY_STRIDE:   r_cfg.copy_stride   <= i_cfg_data;
                CFG_NUM_FATS:      r_cfg.num_fats      <= i_cfg_data[COPY_W-1:0];
                CFG_DATA_BASE:     r_cfg.data_base     <= i_cfg_data;
                CFG_CLUSTER_BYTES: r_cfg.cluster_bytes <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/fccw_walk.sv =====
// Walk state and FAT entry decode: updates the chain state on each transfer
// and describes the results it causes. Depends on fccw_pkg.
module fccw_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fccw_pkg::t_cfg                  i_cfg,
    input  logic                            i_accept,
    input  logic                            i_mode,
    input  logic [fccw_pkg::CLUSTER_W-1:0]  i_start_cluster,
    input  logic [31:0]                     i_file_size,
    input  logic [31:0]                     i_fat_bytes,
    output fccw_pkg::t_work                 o_work
);
    import fccw_pkg::*;

    logic [CLUSTER_W-1:0] r_cl, n_cl;
    logic [COPY_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [31:0]          r_bl, n_bl;
    logic                 r_active, n_active;

    logic [CLUSTER_W-1:0] next_cl, marker, pc_cl;
    logic [31:0]          pc_bl;
    logic [LEN_W-1:0]     csize, len;
    logic                 bad, do_proc;
    t_work                w;

    always_comb begin
        case (i_cfg.fat_type)
            FAT12: begin
                next_cl = r_cl[0] ? CLUSTER_W'(i_fat_bytes[15:4])
                                  : CLUSTER_W'(i_fat_bytes[11:0]);
                marker  = END_FAT12;
            end
            FAT16: begin
                next_cl = CLUSTER_W'(i_fat_bytes[15:0]);
                marker  = END_FAT16;
            end
            default: begin
                next_cl = i_fat_bytes[CLUSTER_W-1:0];
                marker  = END_FAT32;
            end
        endcase
        bad = (next_cl == '0) || (next_cl >= marker) || (next_cl == r_cl);
    end

    always_comb begin
        n_cl     = r_cl;
        n_idx    = r_idx;
        n_base   = r_base;
        n_bl     = r_bl;
        n_active = r_active;
        pc_cl    = r_cl;
        pc_bl    = r_bl;
        do_proc  = 1'b0;
        csize    = eff_csize(i_cfg.cluster_bytes);
        len      = '0;
        w        = '0;
        w.kind0  = KIND_DONE;
        w.kind1  = KIND_DONE;

        if (!i_mode) begin
            if (i_cfg.fat_type == FAT_UNKNOWN) begin
                n_active = 1'b0;
                w.cnt    = 2'd1;
            end else begin
                n_idx    = COPY_W'(1);
                n_base   = i_cfg.fat_base;
                n_active = 1'b1;
                pc_cl    = i_start_cluster;
                pc_bl    = i_file_size;
                do_proc  = 1'b1;
            end
        end else if (r_active) begin
            if (i_cfg.fat_type == FAT_UNKNOWN) begin
                n_active = 1'b0;
                w.cnt    = 2'd1;
            end else if (bad) begin
                if (({1'b0, r_idx} + 5'd1) > {1'b0, i_cfg.num_fats}) begin
                    n_active = 1'b0;
                    w.cnt    = 2'd1;
                end else begin
                    n_idx   = r_idx + COPY_W'(1);
                    n_base  = r_base + i_cfg.copy_stride;
                    w.cnt   = 2'd1;
                    w.kind0 = KIND_FATREQ;
                end
            end else begin
                pc_cl   = next_cl;
                do_proc = 1'b1;
            end
        end

        if (do_proc) begin
            n_cl = pc_cl;
            n_bl = pc_bl;
            if (pc_bl == '0) begin
                n_active = 1'b0;
                w.cnt    = 2'd1;
            end else begin
                len     = (pc_bl < {16'd0, csize}) ? pc_bl[LEN_W-1:0] : csize;
                n_bl    = pc_bl - {16'd0, len};
                w.cnt   = 2'd2;
                w.kind0 = KIND_DATA;
                if (n_bl == '0) begin
                    n_active = 1'b0;
                end else begin
                    w.kind1 = KIND_FATREQ;
                end
            end
        end

        w.cluster   = n_cl;
        w.len       = len;
        w.copy_base = n_base;
        w.fat_type  = i_cfg.fat_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl     <= '0;
            r_idx    <= COPY_W'(1);
            r_base   <= '0;
            r_bl     <= '0;
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_cl     <= n_cl;
            r_idx    <= n_idx;
            r_base   <= n_base;
            r_bl     <= n_bl;
            r_active <= n_active;
        end
    end

    assign o_work = w;

endmodule

// ===== hw/rtl/fccw_result.sv =====
// Work register, address calculation and two-entry result buffer.
// Depends on fccw_pkg.
module fccw_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fccw_pkg::t_cfg                i_cfg,
    input  logic                          i_load,
    input  fccw_pkg::t_work               i_work,
    output logic                          o_in_ready,
    output logic                          o_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [fccw_pkg::ADDR_W-1:0]   o_address,
    output logic [fccw_pkg::LEN_W-1:0]    o_length,
    output logic                          o_last
);
    import fccw_pkg::*;

    logic        r_wv;
    t_work       r_work;
    logic [1:0]  r_cnt, n_cnt;
    t_res        r_s0, r_s1, n_s0, n_s1;

    logic        pop, move;
    logic [1:0]  cnt_after;
    logic [ADDR_W-1:0] off, data_addr, fat_off, fat_addr, c3;
    logic [47:0] prod;
    t_res        res0, res1;

    always_comb begin
        off       = {4'd0, r_work.cluster} - 32'd2;
        prod      = off * eff_csize(i_cfg.cluster_bytes);
        data_addr = i_cfg.data_base + prod[ADDR_W-1:0];
        c3        = {3'd0, r_work.cluster, 1'b0} + {4'd0, r_work.cluster};
        case (r_work.fat_type)
            FAT12:   fat_off = {1'b0, c3[ADDR_W-1:1]};
            FAT16:   fat_off = {3'd0, r_work.cluster, 1'b0};
            default: fat_off = {2'd0, r_work.cluster, 2'd0};
        endcase
        fat_addr = fat_off + r_work.copy_base;
    end

    function automatic t_res mk_res(input t_kind k, input logic lst,
                                    input logic [ADDR_W-1:0] da,
                                    input logic [ADDR_W-1:0] fa,
                                    input logic [LEN_W-1:0] ln);
        t_res r;
        r.kind = k;
        r.last = lst;
        case (k)
            KIND_DATA: begin
                r.addr = da;
                r.len  = ln;
            end
            KIND_FATREQ: begin
                r.addr = fa;
                r.len  = '0;
            end
            default: begin
                r.addr = '0;
                r.len  = '0;
            end
        endcase
        return r;
    endfunction

    always_comb begin
        res0 = mk_res(r_work.kind0, r_work.cnt == 2'd1, data_addr, fat_addr, r_work.len);
        res1 = mk_res(r_work.kind1, 1'b1, data_addr, fat_addr, r_work.len);
    end

    always_comb begin
        pop        = (r_cnt != 2'd0) && i_out_ready;
        cnt_after  = r_cnt - {1'b0, pop};
        move       = r_wv && (({1'b0, cnt_after} + {1'b0, r_work.cnt}) <= 3'd2);
        o_in_ready = !r_wv || move;

        n_s0  = pop ? r_s1 : r_s0;
        n_s1  = r_s1;
        n_cnt = cnt_after;
        if (move) begin
            n_cnt = cnt_after + r_work.cnt;
            case (cnt_after)
                2'd0: begin
                    n_s0 = res0;
                    n_s1 = res1;
                end
                2'd1: n_s1 = res0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_load) begin
                r_wv <= 1'b1;
            end else if (move) begin
                r_wv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= i_work;
        end
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

    assign o_valid   = (r_cnt != 2'd0);
    assign o_kind    = r_s0.kind;
    assign o_address = r_s0.addr;
    assign o_length  = r_s0.len;
    assign o_last    = r_s0.last;

endmodule

// ===== hw/rtl/fat_cluster_chain_walker.sv =====
// FAT12/16/32 cluster chain walker. An input goes through the work register
// into the result buffer. Throughput: one input per cycle unless the output
// stalls; an item with two results can hold the input, set by the one-result-
// per-cycle output buffer. Reset (synchronous, active low) restores the register
// defaults, clears the walk state to idle and empties all pipeline stages.
module fat_cluster_chain_walker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_mode,
    input  logic [fccw_pkg::CLUSTER_W-1:0]  i_start_cluster,
    input  logic [31:0]                     i_file_size,
    input  logic [31:0]                     i_fat_bytes,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [31:0]                     o_address,
    output logic [15:0]                     o_length,
    output logic                            o_last
);
    import fccw_pkg::*;

    t_cfg  cfg;
    t_work work;
    logic  accept;

    assign accept = i_valid && o_ready;

    fccw_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fccw_walk u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_accept        (accept),
        .i_mode          (i_mode),
        .i_start_cluster (i_start_cluster),
        .i_file_size     (i_file_size),
        .i_fat_bytes     (i_fat_bytes),
        .o_work          (work)
    );

    fccw_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_load      (accept),
        .i_work      (work),
        .o_in_ready  (o_ready),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .o_kind      (o_kind),
        .o_address   (o_address),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for fat_cluster_chain_walker: self-checking cluster chain walks
// for FAT12/16/32, with random handshake gaps. Depends on fccw_pkg and the block.
module tb;
    import fccw_pkg::*;

    localparam logic       MODE_START   = 1'b0;
    localparam logic       MODE_REPLY   = 1'b1;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int         DRAIN_CYCLES = 6;
    localparam longint     LIMIT_NS     = 64'd20_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [27:0] i_start_cluster;
    logic [31:0] i_file_size;
    logic [31:0] i_fat_bytes;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [31:0] o_address;
    logic [15:0] o_length;
    logic        o_last;

    fat_cluster_chain_walker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_start_cluster (i_start_cluster),
        .i_file_size     (i_file_size),
        .i_fat_bytes     (i_fat_bytes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_address       (o_address),
        .o_length        (o_length),
        .o_last          (o_last)
    );

    // register copies
    t_fat_type   cfg_type      = FAT12;
    logic [31:0] cfg_fat_base  = 32'd512;
    logic [31:0] cfg_stride    = 32'd4608;
    logic [3:0]  cfg_nfats     = 4'd2;
    logic [31:0] cfg_data_base = 32'd16896;
    logic [15:0] cfg_csize     = 16'd512;

    // walk state
    logic [27:0] walk_cluster   = '0;
    logic [3:0]  walk_copy      = 4'd1;
    logic [31:0] walk_copy_base = '0;
    logic [31:0] walk_left      = '0;
    logic        walk_on        = 1'b0;

    t_res want_q[$];

    int unsigned hold_off   = 0;
    bit          no_idle    = 1'b0;
    int unsigned n_errors   = 0;
    int unsigned n_results  = 0;
    int unsigned n_starts   = 0;
    int unsigned n_replies  = 0;
    int unsigned n_settings = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        #(LIMIT_NS);
        $display("run did not finish in time, %0d results still pending", want_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic void queue_result(t_kind k, logic [31:0] a, logic [15:0] l, logic lst);
        t_res r;
        r.kind = k;
        r.addr = a;
        r.len  = l;
        r.last = lst;
        want_q.push_back(r);
    endfunction

    function automatic void end_walk();
        walk_on = 1'b0;
        queue_result(KIND_DONE, '0, '0, 1'b1);
    endfunction

    function automatic logic [31:0] entry_addr();
        logic [31:0] c;
        c = {4'd0, walk_cluster};
        case (cfg_type)
            FAT12:   entry_addr = ((c * 32'd3) >> 1) + walk_copy_base;
            FAT16:   entry_addr = (c << 1) + walk_copy_base;
            default: entry_addr = (c << 2) + walk_copy_base;
        endcase
    endfunction

    function automatic void emit_cluster();
        logic [31:0] csize, take, addr;
        csize = (cfg_csize == '0) ? 32'd1 : {16'd0, cfg_csize};
        if (walk_left == '0) begin
            end_walk();
            return;
        end
        take = (walk_left < csize) ? walk_left : csize;
        addr = cfg_data_base + ({4'd0, walk_cluster} - 32'd2) * csize;
        walk_left = walk_left - take;
        queue_result(KIND_DATA, addr, take[15:0], 1'b0);
        if (walk_left == '0)
            end_walk();
        else
            queue_result(KIND_FATREQ, entry_addr(), '0, 1'b1);
    endfunction

    function automatic logic [27:0] end_marker();
        case (cfg_type)
            FAT12:   end_marker = END_FAT12;
            FAT16:   end_marker = END_FAT16;
            default: end_marker = END_FAT32;
        endcase
    endfunction

    function automatic void predict(logic mode, logic [27:0] sc, logic [31:0] fs,
                                    logic [31:0] fb);
        logic [27:0] nxt;
        logic [7:0]  b0, b1;
        logic [4:0]  idx;
        if (mode == MODE_START) begin
            if (cfg_type == FAT_UNKNOWN) begin
                end_walk();
                return;
            end
            walk_cluster   = sc;
            walk_left      = fs;
            walk_copy      = 4'd1;
            walk_copy_base = cfg_fat_base;
            walk_on        = 1'b1;
            emit_cluster();
            return;
        end
        if (!walk_on)
            return;
        if (cfg_type == FAT_UNKNOWN) begin
            end_walk();
            return;
        end
        b0 = fb[7:0];
        b1 = fb[15:8];
        case (cfg_type)
            FAT12: begin
                if (walk_cluster[0])
                    nxt = {16'd0, b1, b0[7:4]};
                else
                    nxt = {16'd0, b1[3:0], b0};
            end
            FAT16:   nxt = {12'd0, fb[15:0]};
            default: nxt = fb[27:0];
        endcase
        if (nxt == '0 || nxt >= end_marker() || nxt == walk_cluster) begin
            idx = {1'b0, walk_copy} + 5'd1;
            if (idx > {1'b0, cfg_nfats}) begin
                end_walk();
                return;
            end
            walk_copy      = idx[3:0];
            walk_copy_base = walk_copy_base + cfg_stride;
            queue_result(KIND_FATREQ, entry_addr(), '0, 1'b1);
            return;
        end
        walk_cluster = nxt;
        emit_cluster();
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // FAT reply bytes that decode to entry e for the current cluster
    function automatic logic [31:0] pack_entry(logic [27:0] e);
        logic [31:0] fb;
        fb = $urandom();
        case (cfg_type)
            FAT12: begin
                if (walk_cluster[0])
                    fb[15:4] = e[11:0];
                else
                    fb[11:0] = e[11:0];
            end
            FAT16:   fb[15:0] = e[15:0];
            default: fb[27:0] = e;
        endcase
        return fb;
    endfunction

    function automatic logic [27:0] pick_entry(bit good);
        logic [27:0] lim, top, e;
        lim = end_marker();
        top = (cfg_type == FAT12) ? 28'hFFF : (cfg_type == FAT16) ? 28'hFFFF : 28'hFFFFFFF;
        if (good) begin
            if ($urandom_range(0, 3) == 0)
                e = 28'($urandom_range(1, 16));
            else
                e = 28'($urandom_range(1, lim - 1));
            if (e == walk_cluster)
                e = (e == 28'd1) ? 28'd2 : e - 28'd1;
        end else begin
            case ($urandom_range(0, 2))
                0:       e = '0;
                1:       e = 28'($urandom_range(lim, top));
                default: e = walk_cluster;
            endcase
        end
        return e;
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_csize();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return 32'd32768;
            2:       return 32'd0;
            3:       return $urandom_range(0, 65535);
            default: return 32'd512 << $urandom_range(0, 6);
        endcase
    endfunction

    task automatic send_item(logic mode, logic [27:0] sc, logic [31:0] fs, logic [31:0] fb);
        int unsigned gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_start_cluster <= sc;
        i_file_size     <= fs;
        i_fat_bytes     <= fb;
        do @(posedge i_clk); while (!o_ready);
        predict(mode, sc, fs, fb);
        if (mode == MODE_START)
            n_starts++;
        else
            n_replies++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FAT_TYPE:      cfg_type      = t_fat_type'(val[1:0]);
            CFG_FAT_BASE:      cfg_fat_base  = val;
            CFG_COPY_STRIDE:   cfg_stride    = val;
            CFG_NUM_FATS:      cfg_nfats     = val[3:0];
            CFG_DATA_BASE:     cfg_data_base = val;
            CFG_CLUSTER_BYTES: cfg_csize     = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_random_setting();
        wait_drained();
        write_reg(CFG_FAT_TYPE, ($urandom_range(0, 9) == 0) ? 32'(FAT_UNKNOWN)
                                                             : $urandom_range(0, 2));
        write_reg(CFG_FAT_BASE, pick_addr());
        write_reg(CFG_COPY_STRIDE, pick_addr());
        write_reg(CFG_NUM_FATS, $urandom_range(0, 15));
        write_reg(CFG_DATA_BASE, pick_addr());
        write_reg(CFG_CLUSTER_BYTES, pick_csize());
        n_settings++;
    endtask

    // one item of a walk: mostly replies that follow the chain
    task automatic drive_walk_step(output bit useful);
        int unsigned r, sel;
        logic [31:0] csz, fs;
        logic [27:0] sc;
        r = $urandom_range(0, 99);
        useful = 1'b1;
        if (!walk_on && r < 5) begin
            useful = 1'b0;
            send_item(MODE_REPLY, 28'($urandom()), $urandom(), $urandom());
        end else if (!walk_on || r < 3) begin
            csz = (cfg_csize == '0) ? 32'd1 : {16'd0, cfg_csize};
            sel = $urandom_range(0, 19);
            sc  = (sel == 0) ? 28'($urandom_range(0, 1)) :
                  (sel == 1) ? 28'($urandom()) : 28'($urandom_range(2, 5000));
            sel = $urandom_range(0, 19);
            fs  = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom() : $urandom_range(1, 5 * csz);
            send_item(MODE_START, sc, fs, $urandom());
        end else if (r < 6) begin
            send_item(MODE_REPLY, 28'($urandom()), $urandom(), $urandom());
        end else begin
            send_item(MODE_REPLY, 28'($urandom()), $urandom(),
                      pack_entry(pick_entry(r >= 20)));
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed_cases();
        send_item(MODE_REPLY, '0, '0, 32'hFFFF_FFFF);           // reply while idle
        send_item(MODE_START, 28'd2, 32'd0, '0);                 // empty file
        send_item(MODE_START, 28'd3, 32'd1300, '0);
        send_item(MODE_REPLY, '0, '0, pack_entry(28'd4));        // odd cluster nibbles
        send_item(MODE_REPLY, '0, '0, pack_entry(28'd0));        // free entry, next copy
        send_item(MODE_REPLY, '0, '0, pack_entry(28'hFF8));      // copies used up
        send_item(MODE_START, 28'd0, 32'd100, '1);               // cluster below two
        send_item(MODE_START, 28'd1, 32'd2000, '0);
        send_item(MODE_START, 28'hFFFFFFF, 32'hFFFF_FFFF, '0);   // restart mid-walk
        send_item(MODE_REPLY, '1, '1, pack_entry(28'hFF7));
        wait_drained();
        write_reg(CFG_FAT_TYPE, 32'(FAT16));
        write_reg(CFG_NUM_FATS, 32'd15);
        send_item(MODE_START, 28'd5, 32'd1024, '0);
        send_item(MODE_REPLY, '0, '0, pack_entry(28'd5));        // self link
        send_item(MODE_REPLY, '0, '0, pack_entry(28'hFFF7));
        wait_drained();
        write_reg(CFG_FAT_TYPE, 32'(FAT32));
        write_reg(CFG_CLUSTER_BYTES, 32'd0);
        write_reg(CFG_NUM_FATS, 32'd0);
        send_item(MODE_START, 28'hFFFFFF7, 32'd3, '0);
        send_item(MODE_REPLY, '0, '0, 32'hFFFF_FFFF);            // end marker, no retry
        send_item(MODE_START, 28'd2, 32'd2, '0);
        send_item(MODE_REPLY, '0, '0, pack_entry(28'hFFFFFF7));
        wait_drained();
        write_reg(CFG_CLUSTER_BYTES, 32'd32768);
        write_reg(CFG_NUM_FATS, 32'd1);
        send_item(MODE_START, 28'd9, 32'h0001_0001, '0);
        wait_drained();
        write_reg(CFG_FAT_TYPE, 32'(FAT_UNKNOWN));
        send_item(MODE_REPLY, '0, '0, $urandom());               // unknown type, active walk
        send_item(MODE_START, 28'd7, 32'd10, '0);
        wait_drained();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(CFG_FAT_TYPE, 32'(FAT12));
        send_item(MODE_START, 28'd2, 32'd70000, '0);
        send_item(MODE_REPLY, '0, '0, pack_entry(28'd3));        // even cluster nibbles
        wait_drained();
        n_settings++;
    endtask

    task automatic test_output_stall();
        bit useful;
        program_random_setting();
        write_reg(CFG_FAT_TYPE, $urandom_range(0, 2));
        hold_off = 300;
        repeat (40) drive_walk_step(useful);
        wait_drained();
    endtask

    task automatic test_full_rate();
        bit useful;
        program_random_setting();
        write_reg(CFG_FAT_TYPE, $urandom_range(0, 2));
        no_idle = 1'b1;
        repeat (100) drive_walk_step(useful);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_walks(int unsigned phases, int unsigned per_phase);
        bit useful;
        int unsigned done;
        repeat (phases) begin
            program_random_setting();
            done = 0;
            while (done < per_phase) begin
                drive_walk_step(useful);
                if (useful)
                    done++;
                if ($urandom_range(0, 79) == 0)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    // ---------------- result checker ----------------
    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (want_q.size() == 0) begin
                report_error($sformatf("unexpected transfer kind=%0d addr=%h len=%0d last=%b",
                                       o_kind, o_address, o_length, o_last));
            end else begin
                want = want_q.pop_front();
                if (o_kind !== want.kind || o_address !== want.addr ||
                    o_length !== want.len || o_last !== want.last)
                    report_error($sformatf({"exp kind=%0d addr=%h len=%0d last=%b, ",
                                            "got kind=%0d addr=%h len=%0d last=%b"},
                                           want.kind, want.addr, want.len, want.last,
                                           o_kind, o_address, o_length, o_last));
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin
        int unsigned pause;
        pause   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off != 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if (pause != 0) begin
                pause--;
                i_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                pause = pick_gap() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_mode          = MODE_START;
        i_start_cluster = '0;
        i_file_size     = '0;
        i_fat_bytes     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_stall();
        test_full_rate();
        test_random_walks(14, 60);
        wait_drained();

        $display("Walked chains with %0d starts and %0d FAT replies over %0d register settings,",
                 n_starts, n_replies, n_settings);
        $display("checking %0d result transfers (%0d mismatches).", n_results, n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
